@@ src/ckre_pkg.sv @@
`default_nettype none

package ckre_pkg;

   localparam int MAX_DIM     = 4096;
   localparam int POS_W       = $clog2(MAX_DIM);
   localparam int DIM_W       = POS_W + 1;
   localparam int CHAN_W      = 8;
   localparam int TOTAL_W     = 24;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int ADDR_W      = 5;
   localparam int DATA_W      = 32;
   localparam int IN_DATA_W   = 3 * CHAN_W;
   localparam int OUT_USED_W  = 2 * POS_W + 5 * DIM_W + TOTAL_W;
   localparam int OUT_DATA_W  = ((OUT_USED_W + 7) / 8) * 8;
   localparam int OUT_PAD_W   = OUT_DATA_W - OUT_USED_W;

   localparam logic [CHAN_W-1:0]  CHAN_MAX = '1;
   localparam logic [TOTAL_W-1:0] RUNS_MAX = '1;
   localparam logic [DIM_W-1:0]   DIM_MAX  = DIM_W'(MAX_DIM);

   typedef enum logic [ADDR_W-3:0] {
      REG_KEY_RED,
      REG_KEY_GREEN,
      REG_KEY_BLUE,
      REG_TOL_RED,
      REG_TOL_GREEN,
      REG_TOL_BLUE,
      REG_IMAGE_WIDTH,
      REG_IMAGE_HEIGHT
   } reg_index_type;

   typedef struct packed {
      logic [CHAN_W-1:0] key_red;
      logic [CHAN_W-1:0] key_green;
      logic [CHAN_W-1:0] key_blue;
      logic [CHAN_W-1:0] tol_red;
      logic [CHAN_W-1:0] tol_green;
      logic [CHAN_W-1:0] tol_blue;
      logic [DIM_W-1:0]  image_width;
      logic [DIM_W-1:0]  image_height;
   } cfg_type;

   typedef struct packed {
      logic [CHAN_W-1:0] blue;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] red;
   } pixel_type;

   typedef struct packed {
      logic             has_run;
      logic             has_summary;
      logic [POS_W-1:0] left;
      logic [DIM_W-1:0] right;
      logic [POS_W-1:0] row;
   } cmd_type;

   typedef struct packed {
      logic               kind;
      logic               last;
      logic [TOTAL_W-1:0] run_total;
      logic [DIM_W-1:0]   box_bottom;
      logic [DIM_W-1:0]   box_right;
      logic [DIM_W-1:0]   box_top;
      logic [DIM_W-1:0]   box_left;
      logic [POS_W-1:0]   run_row;
      logic [DIM_W-1:0]   run_right;
      logic [POS_W-1:0]   run_left;
   } result_type;

   localparam logic KIND_RUN     = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
      logic [DIM_W-1:0] r;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (v > DIM_MAX) begin
         r = DIM_MAX;
      end else begin
         r = v;
      end
      return r;
   endfunction

   function automatic logic in_band(input logic [CHAN_W-1:0] pix,
                                    input logic [CHAN_W-1:0] key,
                                    input logic [CHAN_W-1:0] tol);
      logic [CHAN_W:0]   sum;
      logic [CHAN_W-1:0] hi;
      sum = {1'b0, key} + {1'b0, tol};
      hi  = sum[CHAN_W] ? CHAN_MAX : sum[CHAN_W-1:0];
      return (pix >= key) && (pix <= hi);
   endfunction

endpackage

`default_nettype wire

@@ src/ckre_csr.sv @@
`default_nettype none

module ckre_csr (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_psel,
   input  wire logic                          csr_penable,
   input  wire logic                          csr_pwrite,
   input  wire logic [ckre_pkg::ADDR_W-1:0]   csr_paddr,
   input  wire logic [ckre_pkg::DATA_W-1:0]   csr_pwdata,
   output      logic [ckre_pkg::DATA_W-1:0]   csr_prdata,
   output      ckre_pkg::cfg_type             cfg
);

   ckre_pkg::cfg_type       cfg_ff;
   ckre_pkg::cfg_type       cfg_in;
   ckre_pkg::reg_index_type index;
   logic                    wr_en;

   assign index = ckre_pkg::reg_index_type'(csr_paddr[ckre_pkg::ADDR_W-1:2]);
   assign wr_en = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (index)
            ckre_pkg::REG_KEY_RED:      cfg_in.key_red   = csr_pwdata[ckre_pkg::CHAN_W-1:0];
            ckre_pkg::REG_KEY_GREEN:    cfg_in.key_green = csr_pwdata[ckre_pkg::CHAN_W-1:0];
            ckre_pkg::REG_KEY_BLUE:     cfg_in.key_blue  = csr_pwdata[ckre_pkg::CHAN_W-1:0];
            ckre_pkg::REG_TOL_RED:      cfg_in.tol_red   = csr_pwdata[ckre_pkg::CHAN_W-1:0];
            ckre_pkg::REG_TOL_GREEN:    cfg_in.tol_green = csr_pwdata[ckre_pkg::CHAN_W-1:0];
            ckre_pkg::REG_TOL_BLUE:     cfg_in.tol_blue  = csr_pwdata[ckre_pkg::CHAN_W-1:0];
            ckre_pkg::REG_IMAGE_WIDTH:
               cfg_in.image_width  = csr_pwdata[ckre_pkg::DIM_W-1:0];
            ckre_pkg::REG_IMAGE_HEIGHT:
               cfg_in.image_height = csr_pwdata[ckre_pkg::DIM_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (index)
         ckre_pkg::REG_KEY_RED:      csr_prdata = ckre_pkg::DATA_W'(cfg_ff.key_red);
         ckre_pkg::REG_KEY_GREEN:    csr_prdata = ckre_pkg::DATA_W'(cfg_ff.key_green);
         ckre_pkg::REG_KEY_BLUE:     csr_prdata = ckre_pkg::DATA_W'(cfg_ff.key_blue);
         ckre_pkg::REG_TOL_RED:      csr_prdata = ckre_pkg::DATA_W'(cfg_ff.tol_red);
         ckre_pkg::REG_TOL_GREEN:    csr_prdata = ckre_pkg::DATA_W'(cfg_ff.tol_green);
         ckre_pkg::REG_TOL_BLUE:     csr_prdata = ckre_pkg::DATA_W'(cfg_ff.tol_blue);
         ckre_pkg::REG_IMAGE_WIDTH:  csr_prdata = ckre_pkg::DATA_W'(cfg_ff.image_width);
         ckre_pkg::REG_IMAGE_HEIGHT: csr_prdata = ckre_pkg::DATA_W'(cfg_ff.image_height);
         default:                    csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{key_red: '0, key_green: '0, key_blue: '0,
                     tol_red: '0, tol_green: '0, tol_blue: '0,
                     image_width: ckre_pkg::DIM_W'(64),
                     image_height: ckre_pkg::DIM_W'(64)};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

@@ src/ckre_front.sv @@
`default_nettype none

module ckre_front (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire ckre_pkg::cfg_type   cfg,
   input  wire logic                pix_valid,
   input  wire ckre_pkg::pixel_type pix,
   output      logic                pix_ready,
   input  wire logic                q_full,
   output      logic                q_push,
   output      ckre_pkg::cmd_type   q_cmd
);

   logic [ckre_pkg::POS_W-1:0] col_ff, col_in;
   logic [ckre_pkg::POS_W-1:0] row_ff, row_in;
   logic [ckre_pkg::POS_W-1:0] run_start_ff, run_start_in;
   logic                       in_run_ff, in_run_in;

   logic [ckre_pkg::DIM_W-1:0] w, h, col_plus, row_plus;
   logic [ckre_pkg::POS_W-1:0] start;
   logic                       clear, row_end, frame_end, accept;

   assign pix_ready = !q_full;
   assign accept    = pix_valid && pix_ready;

   always_comb begin
      w         = ckre_pkg::clamp_dim(cfg.image_width);
      h         = ckre_pkg::clamp_dim(cfg.image_height);
      col_plus  = {1'b0, col_ff} + ckre_pkg::DIM_W'(1);
      row_plus  = {1'b0, row_ff} + ckre_pkg::DIM_W'(1);
      row_end   = col_plus >= w;
      frame_end = row_end && (row_plus >= h);
      clear     = ckre_pkg::in_band(pix.red,   cfg.key_red,   cfg.tol_red)   &&
                  ckre_pkg::in_band(pix.green, cfg.key_green, cfg.tol_green) &&
                  ckre_pkg::in_band(pix.blue,  cfg.key_blue,  cfg.tol_blue);
      start     = in_run_ff ? run_start_ff : col_ff;

      q_cmd.has_run     = clear ? in_run_ff : row_end;
      q_cmd.has_summary = frame_end;
      q_cmd.left        = start;
      q_cmd.right       = clear ? {1'b0, col_ff} : col_plus;
      q_cmd.row         = row_ff;
      q_push            = accept && (q_cmd.has_run || q_cmd.has_summary);

      in_run_in    = !clear && !row_end;
      run_start_in = start;
      if (frame_end) begin
         col_in = '0;
         row_in = '0;
      end else if (row_end) begin
         col_in = '0;
         row_in = row_plus[ckre_pkg::POS_W-1:0];
      end else begin
         col_in = col_plus[ckre_pkg::POS_W-1:0];
         row_in = row_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         run_start_ff <= '0;
         in_run_ff    <= 1'b0;
      end else if (accept) begin
         col_ff       <= col_in;
         row_ff       <= row_in;
         run_start_ff <= run_start_in;
         in_run_ff    <= in_run_in;
      end
   end

endmodule

`default_nettype wire

@@ src/ckre_queue.sv @@
`default_nettype none

module ckre_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire ckre_pkg::cmd_type push_cmd,
   input  wire logic              pop,
   output      ckre_pkg::cmd_type head_cmd,
   output      logic              empty,
   output      logic              full
);

   ckre_pkg::cmd_type           slot_ff [ckre_pkg::QUEUE_DEPTH];
   logic [ckre_pkg::QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [ckre_pkg::QPTR_W:0]   count_ff, count_in;
   logic                        do_pop;

   assign empty    = count_ff == '0;
   assign full     = count_ff == (ckre_pkg::QPTR_W + 1)'(ckre_pkg::QUEUE_DEPTH);
   assign head_cmd = slot_ff[rd_ptr_ff];
   assign do_pop   = pop && !empty;

   always_comb begin
      count_in = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + (ckre_pkg::QPTR_W + 1)'(1);
      end else if (do_pop && !push) begin
         count_in = count_ff - (ckre_pkg::QPTR_W + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + ckre_pkg::QPTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + ckre_pkg::QPTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

@@ src/ckre_back.sv @@
`default_nettype none

module ckre_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 q_empty,
   input  wire ckre_pkg::cmd_type    q_cmd,
   output      logic                 q_pop,
   output      logic                 res_valid,
   input  wire logic                 res_ready,
   output      ckre_pkg::result_type res
);

   logic [ckre_pkg::DIM_W-1:0]   left_ff, left_in;
   logic [ckre_pkg::DIM_W-1:0]   top_ff, top_in;
   logic [ckre_pkg::DIM_W-1:0]   right_ff, right_in;
   logic [ckre_pkg::DIM_W-1:0]   bottom_ff, bottom_in;
   logic [ckre_pkg::TOTAL_W-1:0] total_ff, total_in;
   logic                         phase_ff, phase_in;
   logic                         valid_ff, valid_in;
   ckre_pkg::result_type         res_ff, res_in;

   logic                         load, take_run;
   logic [ckre_pkg::DIM_W-1:0]   run_left_x, run_row_x, run_row_plus;

   assign load     = !q_empty && (!valid_ff || res_ready);
   assign take_run = q_cmd.has_run && !phase_ff;

   always_comb begin
      run_left_x   = {1'b0, q_cmd.left};
      run_row_x    = {1'b0, q_cmd.row};
      run_row_plus = run_row_x + ckre_pkg::DIM_W'(1);

      left_in   = left_ff;
      top_in    = top_ff;
      right_in  = right_ff;
      bottom_in = bottom_ff;
      total_in  = total_ff;
      phase_in  = phase_ff;
      res_in    = '0;
      q_pop     = 1'b0;

      if (load) begin
         if (take_run) begin
            res_in.kind      = ckre_pkg::KIND_RUN;
            res_in.run_left  = q_cmd.left;
            res_in.run_right = q_cmd.right;
            res_in.run_row   = q_cmd.row;
            res_in.last      = !q_cmd.has_summary;
            if (run_left_x < left_ff)     left_in   = run_left_x;
            if (run_row_x < top_ff)       top_in    = run_row_x;
            if (q_cmd.right > right_ff)   right_in  = q_cmd.right;
            if (run_row_plus > bottom_ff) bottom_in = run_row_plus;
            if (total_ff != ckre_pkg::RUNS_MAX) begin
               total_in = total_ff + ckre_pkg::TOTAL_W'(1);
            end
            phase_in = q_cmd.has_summary;
            q_pop    = !q_cmd.has_summary;
         end else begin
            res_in.kind      = ckre_pkg::KIND_SUMMARY;
            res_in.last      = 1'b1;
            res_in.run_total = total_ff;
            if (total_ff != '0) begin
               res_in.box_left   = left_ff;
               res_in.box_top    = top_ff;
               res_in.box_right  = right_ff;
               res_in.box_bottom = bottom_ff;
            end
            left_in   = ckre_pkg::DIM_MAX;
            top_in    = ckre_pkg::DIM_MAX;
            right_in  = '0;
            bottom_in = '0;
            total_in  = '0;
            phase_in  = 1'b0;
            q_pop     = 1'b1;
         end
      end

      if (load) begin
         valid_in = 1'b1;
      end else if (res_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff   <= ckre_pkg::DIM_MAX;
         top_ff    <= ckre_pkg::DIM_MAX;
         right_ff  <= '0;
         bottom_ff <= '0;
         total_ff  <= '0;
         phase_ff  <= 1'b0;
         valid_ff  <= 1'b0;
      end else begin
         left_ff   <= left_in;
         top_ff    <= top_in;
         right_ff  <= right_in;
         bottom_ff <= bottom_in;
         total_ff  <= total_in;
         phase_ff  <= phase_in;
         valid_ff  <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         res_ff <= res_in;
      end
   end

   assign res_valid = valid_ff;
   assign res       = res_ff;

`ifndef SYNTH
   a_phase_head: assert property (@(posedge clock) disable iff (reset)
      phase_ff |-> (!q_empty && q_cmd.has_summary))
      else $error("split item without a pending summary at the queue head");

   a_summary_last: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && res_ff.kind == ckre_pkg::KIND_SUMMARY) |-> res_ff.last)
      else $error("summary item not marked last");

   a_box_cleared: assert property (@(posedge clock) disable iff (reset)
      (load && !take_run) |=> (total_ff == '0 && left_ff == ckre_pkg::DIM_MAX))
      else $error("frame state not cleared after summary");

   a_run_nonempty: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && res_ff.kind == ckre_pkg::KIND_RUN) |->
         (res_ff.run_right > {1'b0, res_ff.run_left}))
      else $error("run with no opaque pixel");
`endif

endmodule

`default_nettype wire

@@ src/color_key_run_extractor.sv @@
`default_nettype none

// channel   direction   handshake                  payload
// req       in          req_tvalid / req_tready    one pixel: red, green, blue
// rsp       out         rsp_tvalid / rsp_tready    run or summary, tuser kind, tlast
// csr       in          psel / penable, pready=1   eight key, tolerance, size registers
//
// one pixel accepted per cycle while the command queue is not full; a run passes through the command
// queue and the result register before rsp offers it; a pixel that closes a run and ends the frame gives two
// items, the run and then the summary; the four-entry command queue sets how long req keeps going while rsp stalls
// req_tready falls only when that queue is full
// synchronous reset clears counters, box and queue; no clearing pass is needed

module color_key_run_extractor (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // pix_red [7:0], pix_green [15:8], pix_blue [23:16]
   input  wire logic [ckre_pkg::IN_DATA_W-1:0]    req_tdata,
   input  wire logic                              req_tvalid,
   output      logic                              req_tready,
   // run_left, run_right, run_row, box_left, box_top, box_right, box_bottom,
   // run_total, zero fill
   output      logic [ckre_pkg::OUT_DATA_W-1:0]   rsp_tdata,
   // kind
   output      logic                              rsp_tuser,
   output      logic                              rsp_tlast,
   output      logic                              rsp_tvalid,
   input  wire logic                              rsp_tready,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [ckre_pkg::ADDR_W-1:0]       csr_paddr,
   input  wire logic [ckre_pkg::DATA_W-1:0]       csr_pwdata,
   output      logic [ckre_pkg::DATA_W-1:0]       csr_prdata,
   output      logic                              csr_pready
);

   ckre_pkg::cfg_type    cfg;
   ckre_pkg::pixel_type  pix;
   ckre_pkg::cmd_type    push_cmd, head_cmd;
   ckre_pkg::result_type res;
   logic                 q_push, q_pop, q_empty, q_full;

   assign csr_pready = 1'b1;
   assign pix        = ckre_pkg::pixel_type'(req_tdata);

   ckre_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .cfg         (cfg)
   );

   ckre_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .pix_valid (req_tvalid),
      .pix       (pix),
      .pix_ready (req_tready),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_cmd     (push_cmd)
   );

   ckre_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (push_cmd),
      .pop      (q_pop),
      .head_cmd (head_cmd),
      .empty    (q_empty),
      .full     (q_full)
   );

   ckre_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_cmd     (head_cmd),
      .q_pop     (q_pop),
      .res_valid (rsp_tvalid),
      .res_ready (rsp_tready),
      .res       (res)
   );

   assign rsp_tdata = {{ckre_pkg::OUT_PAD_W{1'b0}}, res.run_total, res.box_bottom,
                       res.box_right, res.box_top, res.box_left, res.run_row,
                       res.run_right, res.run_left};
   assign rsp_tuser = res.kind;
   assign rsp_tlast = res.last;

endmodule

`default_nettype wire

@@ tb/sv/color_key_run_extractor_test.sv @@
`timescale 1ns / 100ps

module color_key_run_extractor_test;

   localparam int LONG_HOLD  = 300;
   localparam int STALL_LIMIT = 3000;
   localparam int RANDOM_PIXELS = 1650;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic [ckre_pkg::IN_DATA_W-1:0]  req_tdata = '0;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [ckre_pkg::OUT_DATA_W-1:0] rsp_tdata;
   logic                            rsp_tuser;
   logic                            rsp_tlast;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic                            csr_psel = 1'b0;
   logic                            csr_penable = 1'b0;
   logic                            csr_pwrite = 1'b0;
   logic [ckre_pkg::ADDR_W-1:0]     csr_paddr = '0;
   logic [ckre_pkg::DATA_W-1:0]     csr_pwdata = '0;
   logic [ckre_pkg::DATA_W-1:0]     csr_prdata;
   logic                            csr_pready;

   color_key_run_extractor dut (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   ckre_pkg::pixel_type  pixels_to_send[$];
   ckre_pkg::result_type runs_awaited[$];
   int         bad_run_items = 0;
   bit         idling = 1'b1;
   int         hold_asks = 0;
   int         hold_done = 0;

   // shadow of the key, tolerance and size registers
   ckre_pkg::cfg_type cfg_now = '{key_red: '0, key_green: '0, key_blue: '0,
                                  tol_red: '0, tol_green: '0, tol_blue: '0,
                                  image_width: ckre_pkg::DIM_W'(64),
                                  image_height: ckre_pkg::DIM_W'(64)};

   // frame state of the run tracker
   int col_pos = 0;
   int row_pos = 0;
   bit run_open = 1'b0;
   int run_from = 0;
   int box_l = ckre_pkg::MAX_DIM;
   int box_t = ckre_pkg::MAX_DIM;
   int box_r = 0;
   int box_b = 0;
   int run_tally = 0;

   function automatic int effective_dim(logic [ckre_pkg::DIM_W-1:0] v);
      if (v == '0) return 1;
      if (int'(v) > ckre_pkg::MAX_DIM) return ckre_pkg::MAX_DIM;
      return int'(v);
   endfunction

   function automatic bit keyed_channel(logic [ckre_pkg::CHAN_W-1:0] pix,
                                        logic [ckre_pkg::CHAN_W-1:0] key,
                                        logic [ckre_pkg::CHAN_W-1:0] tol);
      int top;
      top = int'(key) + int'(tol);
      if (top > 255) top = 255;
      return int'(pix) >= int'(key) && int'(pix) <= top;
   endfunction

   function automatic ckre_pkg::result_type close_run(int left, int right, int row);
      ckre_pkg::result_type r;
      r = '0;
      r.kind = ckre_pkg::KIND_RUN;
      r.run_left = ckre_pkg::POS_W'(left);
      r.run_right = ckre_pkg::DIM_W'(right);
      r.run_row = ckre_pkg::POS_W'(row);
      if (left < box_l) box_l = left;
      if (row < box_t) box_t = row;
      if (right > box_r) box_r = right;
      if (row + 1 > box_b) box_b = row + 1;
      if (run_tally < int'(ckre_pkg::RUNS_MAX)) run_tally++;
      return r;
   endfunction

   function automatic void extract_runs(ckre_pkg::pixel_type px);
      ckre_pkg::result_type made[2];
      int n;
      int w;
      int h;
      bit clear_px;
      bit row_done;
      bit frame_done;
      n = 0;
      w = effective_dim(cfg_now.image_width);
      h = effective_dim(cfg_now.image_height);
      clear_px = keyed_channel(px.red, cfg_now.key_red, cfg_now.tol_red) &&
                 keyed_channel(px.green, cfg_now.key_green, cfg_now.tol_green) &&
                 keyed_channel(px.blue, cfg_now.key_blue, cfg_now.tol_blue);
      row_done = col_pos + 1 >= w;
      frame_done = row_done && (row_pos + 1 >= h);
      if (clear_px) begin
         if (run_open) begin
            made[n] = close_run(run_from, col_pos, row_pos);
            n++;
            run_open = 1'b0;
         end
      end else begin
         if (!run_open) begin
            run_open = 1'b1;
            run_from = col_pos;
         end
         if (row_done) begin
            made[n] = close_run(run_from, col_pos + 1, row_pos);
            n++;
            run_open = 1'b0;
         end
      end
      if (frame_done) begin
         made[n] = '0;
         made[n].kind = ckre_pkg::KIND_SUMMARY;
         if (run_tally != 0) begin
            made[n].box_left = ckre_pkg::DIM_W'(box_l);
            made[n].box_top = ckre_pkg::DIM_W'(box_t);
            made[n].box_right = ckre_pkg::DIM_W'(box_r);
            made[n].box_bottom = ckre_pkg::DIM_W'(box_b);
         end
         made[n].run_total = ckre_pkg::TOTAL_W'(run_tally);
         n++;
         col_pos = 0;
         row_pos = 0;
         run_open = 1'b0;
         run_from = 0;
         box_l = ckre_pkg::MAX_DIM;
         box_t = ckre_pkg::MAX_DIM;
         box_r = 0;
         box_b = 0;
         run_tally = 0;
      end else if (row_done) begin
         run_open = 1'b0;
         col_pos = 0;
         row_pos++;
      end else begin
         col_pos++;
      end
      if (n > 0) made[n-1].last = 1'b1;
      for (int i = 0; i < n; i++) runs_awaited.push_back(made[i]);
   endfunction

   function automatic string describe(ckre_pkg::result_type r);
      return $sformatf("kind %0d last %0d run %0d..%0d row %0d box %0d,%0d,%0d,%0d total %0d",
                       r.kind, r.last, r.run_left, r.run_right, r.run_row, r.box_left,
                       r.box_top, r.box_right, r.box_bottom, r.run_total);
   endfunction

   // sender
   int gap_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         gap_left <= 0;
      end else if (!req_tvalid || req_tready) begin
         if (gap_left != 0) begin
            gap_left <= gap_left - 1;
            req_tvalid <= 1'b0;
         end else if (idling && $urandom_range(0, 9) == 0) begin
            gap_left <= $urandom_range(0, 14);
            req_tvalid <= 1'b0;
         end else if (pixels_to_send.size() != 0) begin
            req_tdata <= pixels_to_send.pop_front();
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver
   int stall_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
      end else if (hold_done != hold_asks) begin
         hold_done <= hold_asks;
         stall_left <= LONG_HOLD - 1;
         rsp_tready <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (idling && $urandom_range(0, 9) == 0) begin
         stall_left <= $urandom_range(0, 14);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // monitor
   always @(posedge clock) begin
      ckre_pkg::result_type got;
      ckre_pkg::result_type want;
      if (!reset) begin
         if (req_tvalid && req_tready) extract_runs(ckre_pkg::pixel_type'(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            got = '0;
            got.kind = rsp_tuser;
            got.last = rsp_tlast;
            {got.run_total, got.box_bottom, got.box_right, got.box_top, got.box_left,
             got.run_row, got.run_right, got.run_left} = rsp_tdata[ckre_pkg::OUT_USED_W-1:0];
            if (runs_awaited.size() == 0) begin
               bad_run_items++;
               if (bad_run_items <= 10) $display("unexpected item: %s", describe(got));
            end else begin
               want = runs_awaited.pop_front();
               if (got.kind != want.kind || got.last != want.last ||
                   got.run_left != want.run_left || got.run_right != want.run_right ||
                   got.run_row != want.run_row || got.box_left != want.box_left ||
                   got.box_top != want.box_top || got.box_right != want.box_right ||
                   got.box_bottom != want.box_bottom || got.run_total != want.run_total) begin
                  bad_run_items++;
                  if (bad_run_items <= 10) begin
                     $display("item mismatch: expected %s", describe(want));
                     $display("                 actual %s", describe(got));
                  end
               end
            end
         end
      end
   end

   // watchdog
   int quiet_cycles = 0;
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_psel ||
          (pixels_to_send.size() == 0 && !req_tvalid && runs_awaited.size() == 0)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic write_csr(ckre_pkg::reg_index_type idx, int unsigned value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         ckre_pkg::REG_KEY_RED:      cfg_now.key_red = value[7:0];
         ckre_pkg::REG_KEY_GREEN:    cfg_now.key_green = value[7:0];
         ckre_pkg::REG_KEY_BLUE:     cfg_now.key_blue = value[7:0];
         ckre_pkg::REG_TOL_RED:      cfg_now.tol_red = value[7:0];
         ckre_pkg::REG_TOL_GREEN:    cfg_now.tol_green = value[7:0];
         ckre_pkg::REG_TOL_BLUE:     cfg_now.tol_blue = value[7:0];
         ckre_pkg::REG_IMAGE_WIDTH:  cfg_now.image_width = value[12:0];
         ckre_pkg::REG_IMAGE_HEIGHT: cfg_now.image_height = value[12:0];
         default: ;
      endcase
   endtask

   task automatic set_keys(int kr, int kg, int kb, int tr, int tg, int tb);
      write_csr(ckre_pkg::REG_KEY_RED, kr);
      write_csr(ckre_pkg::REG_KEY_GREEN, kg);
      write_csr(ckre_pkg::REG_KEY_BLUE, kb);
      write_csr(ckre_pkg::REG_TOL_RED, tr);
      write_csr(ckre_pkg::REG_TOL_GREEN, tg);
      write_csr(ckre_pkg::REG_TOL_BLUE, tb);
      @(negedge clock);
   endtask

   task automatic set_size(int w, int h);
      write_csr(ckre_pkg::REG_IMAGE_WIDTH, w);
      write_csr(ckre_pkg::REG_IMAGE_HEIGHT, h);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (pixels_to_send.size() != 0 || req_tvalid || runs_awaited.size() != 0);
      repeat (8) @(posedge clock);
   endtask

   function automatic void queue_pixel(int r, int g, int b);
      ckre_pkg::pixel_type px;
      px.red = r[7:0];
      px.green = g[7:0];
      px.blue = b[7:0];
      pixels_to_send.push_back(px);
   endfunction

   function automatic int band_value(logic [ckre_pkg::CHAN_W-1:0] key,
                                     logic [ckre_pkg::CHAN_W-1:0] tol);
      int top;
      top = int'(key) + int'(tol);
      if (top > 255) top = 255;
      return $urandom_range(top, int'(key));
   endfunction

   function automatic int pick_byte();
      case ($urandom_range(0, 7))
         0: return 0;
         1: return 255;
         default: return $urandom_range(0, 255);
      endcase
   endfunction

   initial begin
      int sent;
      int phase_no;
      int phase_len;
      int w;
      int mode;
      ckre_pkg::pixel_type px;
      sent = 0;
      phase_no = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // blue band saturates at 255
      set_keys('h10, 'h20, 'hf0, 'h00, 'h05, 'hff);
      set_size(4, 3);
      queue_pixel('h10, 'h20, 'hf0);
      queue_pixel('h00, 'h00, 'h00);
      queue_pixel('hff, 'hff, 'hff);
      queue_pixel('h10, 'h25, 'hff);
      queue_pixel('h0f, 'h20, 'hf0);
      queue_pixel('h10, 'h26, 'hf0);
      queue_pixel('h10, 'h20, 'hff);
      queue_pixel('h11, 'h20, 'hf0);
      queue_pixel('h10, 'h1f, 'hf0);
      queue_pixel('h10, 'h20, 'hef);
      queue_pixel('hff, 'h20, 'hf0);
      queue_pixel('h10, 'h20, 'h00);
      wait_drained();

      // frame with no runs
      set_size(2, 2);
      repeat (4) queue_pixel('h10, 'h22, 'hf8);
      wait_drained();

      // zero sizes act as one
      set_size(0, 0);
      queue_pixel('h00, 'hff, 'h00);
      queue_pixel('h10, 'h20, 'hf0);
      wait_drained();

      // oversized width, then key change inside a run, then width shrunk mid-row
      set_size('h1fff, 0);
      repeat (5) queue_pixel('hff, 'h00, 'hff);
      wait_drained();
      set_keys('haa, 'hbb, 'hcc, 'h00, 'h00, 'h00);
      queue_pixel('haa, 'hbb, 'hcc);
      queue_pixel('hab, 'hbb, 'hcc);
      wait_drained();
      set_size(3, 0);
      queue_pixel('h00, 'h00, 'h00);
      wait_drained();

      while (sent < RANDOM_PIXELS) begin
         if (sent > RANDOM_PIXELS - 300) idling = 1'b0;
         set_keys(pick_byte(), pick_byte(), pick_byte(), pick_byte(), pick_byte(),
                  pick_byte());
         case ($urandom_range(0, 15))
            0: w = 0;
            1: w = $urandom_range(ckre_pkg::MAX_DIM + 1, 8191);
            default: w = $urandom_range(1, 12);
         endcase
         // narrow rows so that results pile up during the long hold
         if (phase_no == 2) w = 2;
         set_size(w, $urandom_range(0, 5));
         phase_len = (phase_no == 2) ? 80 : $urandom_range(10, 120);
         for (int i = 0; i < phase_len; i++) begin
            mode = $urandom_range(0, 3);
            if (mode == 2) begin
               px = ckre_pkg::pixel_type'(ckre_pkg::IN_DATA_W'($urandom));
            end else begin
               px.red = ckre_pkg::CHAN_W'(band_value(cfg_now.key_red, cfg_now.tol_red));
               px.green = ckre_pkg::CHAN_W'(band_value(cfg_now.key_green, cfg_now.tol_green));
               px.blue = ckre_pkg::CHAN_W'(band_value(cfg_now.key_blue, cfg_now.tol_blue));
               if (mode == 3) begin
                  case ($urandom_range(0, 2))
                     0: px.red = ckre_pkg::CHAN_W'($urandom_range(0, 255));
                     1: px.green = ckre_pkg::CHAN_W'($urandom_range(0, 255));
                     default: px.blue = ckre_pkg::CHAN_W'($urandom_range(0, 255));
                  endcase
               end
            end
            pixels_to_send.push_back(px);
         end
         // results pile up behind a long receiver hold while pixels keep coming
         if (phase_no == 2) hold_asks++;
         sent += phase_len;
         phase_no++;
         wait_drained();
      end

      repeat (20) @(posedge clock);
      if (bad_run_items == 0 && runs_awaited.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

@@ color_key_run_extractor.f @@
src/ckre_pkg.sv
src/ckre_csr.sv
src/ckre_front.sv
src/ckre_queue.sv
src/ckre_back.sv
src/color_key_run_extractor.sv
tb/sv/color_key_run_extractor_test.sv
